// ===== hdl/trial_division_prime_tester_macros.svh =====
// assertion macros for the trial division prime tester
// no dependencies; included by the top level
`ifndef TRIAL_DIVISION_PRIME_TESTER_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TESTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TDPT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define TDPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TDPT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TDPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/tdpt_pkg.sv =====
// shared constants, types and state encoding of the trial division prime tester
// no dependencies
package tdpt_pkg;

    localparam int VALUE_BITS = 20;
    localparam int CAND_BITS  = 20;
    localparam int COUNT_BITS = 21;
    localparam int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS    = VALUE_BITS + 1;
    localparam int REM_BITS   = DIV_BITS + 1;
    localparam int STEP_BITS  = $clog2(VALUE_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIVIDE,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [DIV_BITS-1:0]   divisor;
    } t_rem_cmd;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_status;

    typedef struct packed {
        logic [CAND_BITS-1:0]  tested_value;
        logic                  prime_flag;
        logic [COUNT_BITS-1:0] found_total;
        logic                  range_done;
    } t_result;

endpackage

// ===== hdl/tdpt_stream_if.sv =====
// valid/ready stream interfaces for candidates and results
// depends on tdpt_pkg
interface tdpt_in_if;
    logic                           valid;
    logic                           ready;
    logic [tdpt_pkg::CAND_BITS-1:0] candidate;
    logic                           last_of_range;

    modport source (output valid, output candidate, output last_of_range, input ready);
    modport sink   (input valid, input candidate, input last_of_range, output ready);
endinterface

interface tdpt_out_if;
    logic                            valid;
    logic                            ready;
    logic [tdpt_pkg::CAND_BITS-1:0]  tested_value;
    logic                            prime_flag;
    logic [tdpt_pkg::COUNT_BITS-1:0] found_total;
    logic                            range_done;

    modport source (output valid, output tested_value, output prime_flag,
                    output found_total, output range_done, input ready);
    modport sink   (input valid, input tested_value, input prime_flag,
                    input found_total, input range_done, output ready);
endinterface

// ===== hdl/tdpt_rem_unit.sv =====
// shared restoring remainder unit, one dividend bit per cycle
// depends on tdpt_pkg
module tdpt_rem_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tdpt_pkg::t_rem_cmd    i_cmd,
    output tdpt_pkg::t_rem_status o_status
);
    import tdpt_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_BITS-1:0]  r_cnt;
    logic [REM_BITS-1:0]   r_rem;
    logic [REM_BITS-1:0]   n_rem;
    logic [VALUE_BITS-1:0] r_sh;
    logic [DIV_BITS-1:0]   r_div;
    logic [REM_BITS-1:0]   trial;

    always_comb begin
        trial = {r_rem[REM_BITS-2:0], r_sh[VALUE_BITS-1]};
        if (trial >= REM_BITS'(r_div)) begin
            n_rem = trial - REM_BITS'(r_div);
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_BITS'(VALUE_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= '0;
            r_sh  <= i_cmd.dividend;
            r_div <= i_cmd.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= r_sh << 1;
        end
    end

    assign o_status.done = r_done;
    assign o_status.zero = (r_rem == '0);

endmodule

// ===== hdl/tdpt_seq.sv =====
// sequencer: steps the trial divisor, tracks its square and keeps the prime count
// depends on tdpt_pkg and tdpt_rem_unit
module tdpt_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [tdpt_pkg::CAND_BITS-1:0] i_candidate,
    input  logic                           i_last,
    output logic                           o_res_valid,
    output tdpt_pkg::t_result              o_result,
    input  logic                           i_res_take
);
    import tdpt_pkg::*;

    t_seq_state             r_state, n_state;
    logic [VALUE_BITS-1:0]  r_n, n_n;
    logic                   r_last, n_last;
    logic [DIV_BITS-1:0]    r_d, n_d;
    logic [SQ_BITS-1:0]     r_sq, n_sq;
    logic                   r_prime, n_prime;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [COUNT_BITS-1:0]  found;
    t_rem_cmd               rem_cmd;
    t_rem_status            rem_status;

    tdpt_rem_unit u_rem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (rem_cmd),
        .o_status (rem_status)
    );

    assign found = (r_prime && r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;

    always_comb begin
        n_state          = r_state;
        n_n              = r_n;
        n_last           = r_last;
        n_d              = r_d;
        n_sq             = r_sq;
        n_prime          = r_prime;
        n_count          = r_count;
        rem_cmd.start    = 1'b0;
        rem_cmd.dividend = r_n;
        rem_cmd.divisor  = r_d;
        o_in_ready       = 1'b0;
        o_res_valid      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_n     = i_candidate[VALUE_BITS-1:0];
                    n_last  = i_last;
                    n_d     = DIV_BITS'(2);
                    n_sq    = SQ_BITS'(4);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_n < VALUE_BITS'(2)) begin
                    n_prime = 1'b0;
                    n_state = S_DONE;
                end else if (r_sq > SQ_BITS'(r_n)) begin
                    n_prime = 1'b1;
                    n_state = S_DONE;
                end else begin
                    rem_cmd.start = 1'b1;
                    n_state       = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (rem_status.done) begin
                    if (rem_status.zero) begin
                        n_prime = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_d     = r_d + 1'b1;
                        n_sq    = r_sq + SQ_BITS'({r_d, 1'b0}) + SQ_BITS'(1);
                        n_state = S_CHECK;
                    end
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_count = found;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_last  <= n_last;
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_prime <= n_prime;
    end

    assign o_result.tested_value = CAND_BITS'(r_n);
    assign o_result.prime_flag   = r_prime;
    assign o_result.found_total  = found;
    assign o_result.range_done   = r_last;

endmodule

// ===== hdl/trial_division_prime_tester.sv =====
// top level of the trial division prime tester: sequencer and output register
// depends on tdpt_pkg, tdpt_stream_if, tdpt_seq and the assertion macros
//
//  port     | direction | carries
//  i_cand   | in        | candidate, last_of_range
//  o_res    | out       | tested_value, prime_flag, found_total, range_done
//
// one candidate at a time; the shared remainder unit handles one divisor per pass
// (a check step, one bit step per dividend bit, a done step), and a candidate n >= 2
// is tried with divisors from 2 up to floor(sqrt(n)) until one divides it
// reset clears the state and the prime count; i_cand.ready is low while testing
// a finished result waits in the output register; the next candidate is taken meanwhile
`include "trial_division_prime_tester_macros.svh"

module trial_division_prime_tester (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tdpt_in_if.sink    i_cand,
    tdpt_out_if.source o_res
);
    import tdpt_pkg::*;

    logic    res_valid;
    logic    res_take;
    t_result result;
    logic    r_out_valid;
    t_result r_out;

    tdpt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cand.valid),
        .o_in_ready  (i_cand.ready),
        .i_candidate (i_cand.candidate),
        .i_last      (i_cand.last_of_range),
        .o_res_valid (res_valid),
        .o_result    (result),
        .i_res_take  (res_take)
    );

    assign res_take = res_valid && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.tested_value = r_out.tested_value;
    assign o_res.prime_flag   = r_out.prime_flag;
    assign o_res.found_total  = r_out.found_total;
    assign o_res.range_done   = r_out.range_done;

    `TDPT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_cand.valid && i_cand.ready, !i_cand.ready)
    `TDPT_ASSERT_SAME(a_prime_counted, i_clk, i_rst_n, r_out_valid && r_out.prime_flag, r_out.found_total != '0)
    `TDPT_ASSERT_SAME(a_prime_at_least_two, i_clk, i_rst_n, r_out_valid && r_out.prime_flag, r_out.tested_value >= CAND_BITS'(2))
    `TDPT_ASSERT_SAME(a_no_take_while_idle, i_clk, i_rst_n, i_cand.ready, !res_valid)

endmodule
